FILE: rtl/cau_pkg.sv
package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int SUM_W = 66;
   // remainder width for the divider: holds den << 32 and mag << FRAC_BITS (FRAC_BITS <= 30)
   localparam int DIV_W = 97;
   localparam int QUO_W = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_re;
      logic signed [31:0] r_im;
      logic [1:0]         status;
   } rsp_type;

   // front end result: sign and magnitude of both parts plus the denominator
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        dz;
      logic [63:0] den;
      logic        neg_re;
      logic [63:0] mag_re;
      logic        neg_im;
      logic [63:0] mag_im;
   } front_type;

   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        dz;
      logic [63:0] den;
   } div_ctl_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [DIV_W-1:0] r;
      logic [QUO_W-1:0] q;
   } div_lane_type;

endpackage

FILE: rtl/cau_front.sv
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cau_pkg::req_type    in_item,
   output cau_pkg::front_type  out_f
);

   // stage 1: operands and magnitudes of b
   logic v1_ff;
   cau_pkg::op_type op1_ff;
   logic signed [31:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic [31:0] mbr1_ff, mbi1_ff;
   logic [31:0] mbr1_in, mbi1_in;

   // stage 2: products and add/sub
   logic v2_ff;
   cau_pkg::op_type op2_ff;
   logic signed [63:0] prr2_ff, pii2_ff, pir2_ff, pri2_ff;
   logic [63:0] dr2_ff, di2_ff;
   logic signed [32:0] asr2_ff, asi2_ff;
   logic signed [32:0] asr2_in, asi2_in;

   // stage 3: sums and denominator
   logic v3_ff;
   cau_pkg::op_type op3_ff;
   logic signed [65:0] sr3_ff, si3_ff;
   logic signed [65:0] sr3_in, si3_in;
   logic [63:0] den3_ff;

   // stage 4: sign and magnitude
   logic [65:0] absr4_in, absi4_in;
   cau_pkg::front_type f4_ff, f4_in;

   assign mbr1_in = in_item.b_re[31] ? 32'(-in_item.b_re) : 32'(in_item.b_re);
   assign mbi1_in = in_item.b_im[31] ? 32'(-in_item.b_im) : 32'(in_item.b_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         f4_ff.valid <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         f4_ff.valid <= v3_ff;
      end
      f4_ff.op     <= f4_in.op;
      f4_ff.den    <= f4_in.den;
      f4_ff.dz     <= f4_in.dz;
      f4_ff.neg_re <= f4_in.neg_re;
      f4_ff.neg_im <= f4_in.neg_im;
      f4_ff.mag_re <= f4_in.mag_re;
      f4_ff.mag_im <= f4_in.mag_im;
   end

   always_ff @(posedge clock) begin
      op1_ff  <= cau_pkg::op_type'(in_item.opcode);
      ar1_ff  <= in_item.a_re;
      ai1_ff  <= in_item.a_im;
      br1_ff  <= in_item.b_re;
      bi1_ff  <= in_item.b_im;
      mbr1_ff <= mbr1_in;
      mbi1_ff <= mbi1_in;
   end

   always_comb begin
      if (op1_ff == cau_pkg::OP_SUB) begin
         asr2_in = 33'(ar1_ff) - 33'(br1_ff);
         asi2_in = 33'(ai1_ff) - 33'(bi1_ff);
      end else begin
         asr2_in = 33'(ar1_ff) + 33'(br1_ff);
         asi2_in = 33'(ai1_ff) + 33'(bi1_ff);
      end
   end

   always_ff @(posedge clock) begin
      op2_ff  <= op1_ff;
      prr2_ff <= 64'(ar1_ff) * 64'(br1_ff);
      pii2_ff <= 64'(ai1_ff) * 64'(bi1_ff);
      pir2_ff <= 64'(ai1_ff) * 64'(br1_ff);
      pri2_ff <= 64'(ar1_ff) * 64'(bi1_ff);
      dr2_ff  <= 64'(mbr1_ff) * 64'(mbr1_ff);
      di2_ff  <= 64'(mbi1_ff) * 64'(mbi1_ff);
      asr2_ff <= asr2_in;
      asi2_ff <= asi2_in;
   end

   always_comb begin
      unique case (op2_ff)
         cau_pkg::OP_MUL: begin
            sr3_in = 66'(prr2_ff) - 66'(pii2_ff);
            si3_in = 66'(pir2_ff) + 66'(pri2_ff);
         end
         cau_pkg::OP_DIV: begin
            sr3_in = 66'(prr2_ff) + 66'(pii2_ff);
            si3_in = 66'(pir2_ff) - 66'(pri2_ff);
         end
         default: begin
            sr3_in = 66'(asr2_ff);
            si3_in = 66'(asi2_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op3_ff  <= op2_ff;
      sr3_ff  <= sr3_in;
      si3_ff  <= si3_in;
      den3_ff <= dr2_ff + di2_ff;
   end

   // magnitude is at most 2^63, so the low 64 bits hold it; truncation toward zero
   // for the product rescale is a shift of the magnitude
   assign absr4_in = sr3_ff[65] ? 66'(-sr3_ff) : 66'(sr3_ff);
   assign absi4_in = si3_ff[65] ? 66'(-si3_ff) : 66'(si3_ff);

   always_comb begin
      f4_in = f4_ff;
      f4_in.op = op3_ff;
      f4_in.den = den3_ff;
      f4_in.dz = (den3_ff == 64'd0);
      f4_in.neg_re = sr3_ff[65];
      f4_in.neg_im = si3_ff[65];
      if (op3_ff == cau_pkg::OP_MUL) begin
         f4_in.mag_re = absr4_in[63:0] >> FRAC_BITS;
         f4_in.mag_im = absi4_in[63:0] >> FRAC_BITS;
      end else begin
         f4_in.mag_re = absr4_in[63:0];
         f4_in.mag_im = absi4_in[63:0];
      end
   end

   assign out_f = f4_ff;

endmodule

FILE: rtl/cau_div_stage.sv
module cau_div_stage #(
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cau_pkg::div_ctl_type   in_ctl,
   input  cau_pkg::div_lane_type  in_re,
   input  cau_pkg::div_lane_type  in_im,
   output cau_pkg::div_ctl_type   out_ctl,
   output cau_pkg::div_lane_type  out_re,
   output cau_pkg::div_lane_type  out_im
);

   cau_pkg::div_ctl_type ctl_ff;
   cau_pkg::div_lane_type re_ff, im_ff, re_in, im_in;
   logic [cau_pkg::DIV_W-1:0] sub;
   logic go;

   assign sub = cau_pkg::DIV_W'(in_ctl.den) << BIT;
   assign go = (in_ctl.op == cau_pkg::OP_DIV) && !in_ctl.dz;

   // one restoring quotient bit per lane
   always_comb begin
      re_in = in_re;
      im_in = in_im;
      if (go && !in_re.ovf && in_re.r >= sub) begin
         re_in.r = in_re.r - sub;
         re_in.q[BIT] = 1'b1;
      end
      if (go && !in_im.ovf && in_im.r >= sub) begin
         im_in.r = in_im.r - sub;
         im_in.q[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= in_ctl.valid;
      end
      ctl_ff.op  <= in_ctl.op;
      ctl_ff.dz  <= in_ctl.dz;
      ctl_ff.den <= in_ctl.den;
      re_ff      <= re_in;
      im_ff      <= im_in;
   end

   assign out_ctl = ctl_ff;
   assign out_re = re_ff;
   assign out_im = im_ff;

endmodule

FILE: rtl/cau_div.sv
module cau_div #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cau_pkg::front_type     in_f,
   output cau_pkg::div_ctl_type   out_ctl,
   output cau_pkg::div_lane_type  out_re,
   output cau_pkg::div_lane_type  out_im
);

   localparam int NSTG = cau_pkg::QUO_W;

   cau_pkg::div_ctl_type  ctl [0:NSTG];
   cau_pkg::div_lane_type re [0:NSTG];
   cau_pkg::div_lane_type im [0:NSTG];

   cau_pkg::div_ctl_type  hctl_ff;
   cau_pkg::div_lane_type hre_ff, him_ff, hre_in, him_in;
   logic [cau_pkg::DIV_W-1:0] lim;
   logic is_div;

   // head: scale the numerator and flag quotients of 2^32 or more
   assign is_div = (in_f.op == cau_pkg::OP_DIV);
   assign lim = cau_pkg::DIV_W'(in_f.den) << cau_pkg::QUO_W;

   always_comb begin
      hre_in.neg = in_f.neg_re;
      him_in.neg = in_f.neg_im;
      hre_in.q = '0;
      him_in.q = '0;
      if (is_div) begin
         hre_in.r = cau_pkg::DIV_W'(in_f.mag_re) << FRAC_BITS;
         him_in.r = cau_pkg::DIV_W'(in_f.mag_im) << FRAC_BITS;
      end else begin
         hre_in.r = cau_pkg::DIV_W'(in_f.mag_re);
         him_in.r = cau_pkg::DIV_W'(in_f.mag_im);
      end
      hre_in.ovf = is_div && !in_f.dz && (hre_in.r >= lim);
      him_in.ovf = is_div && !in_f.dz && (him_in.r >= lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hctl_ff.valid <= 1'b0;
      end else begin
         hctl_ff.valid <= in_f.valid;
      end
      hctl_ff.op  <= in_f.op;
      hctl_ff.dz  <= in_f.dz;
      hctl_ff.den <= in_f.den;
      hre_ff      <= hre_in;
      him_ff      <= him_in;
   end

   assign ctl[0] = hctl_ff;
   assign re[0] = hre_ff;
   assign im[0] = him_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      cau_div_stage #(
         .BIT(NSTG - 1 - g)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (ctl[g]),
         .in_re   (re[g]),
         .in_im   (im[g]),
         .out_ctl (ctl[g+1]),
         .out_re  (re[g+1]),
         .out_im  (im[g+1])
      );
   end

   assign out_ctl = ctl[NSTG];
   assign out_re = re[NSTG];
   assign out_im = im[NSTG];

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide on signed fixed point.
// Pipeline: 38 register stages from the accepting edge to the rsp_valid strobe.
// Throughput: one item per cycle; busy is low except while reset is high.
// Reset: synchronous, active high; clears the valid bits, items in flight are dropped.
// The receiver cannot stall: each result is on rsp_item for one cycle only.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cau_pkg::req_type  req_item,
   output logic              rsp_valid,
   output cau_pkg::rsp_type  rsp_item
);

   cau_pkg::front_type    front;
   cau_pkg::div_ctl_type  dctl;
   cau_pkg::div_lane_type dre, dim;

   logic                accept;
   logic [63:0]         mag_re, mag_im;
   logic [31:0]         res_re, res_im;
   logic                sat_re, sat_im;
   logic                rsp_valid_ff;
   cau_pkg::rsp_type    rsp_ff, rsp_in;

   // hold off items only while reset is applied
   assign busy = reset;
   assign accept = start && !busy;

   // four stages: operand capture, products, sums, sign and magnitude
   cau_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_item  (req_item),
      .out_f    (front)
   );

   // overflow check plus one quotient bit per stage; other opcodes pass through
   cau_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_f    (front),
      .out_ctl (dctl),
      .out_re  (dre),
      .out_im  (dim)
   );

   // pick the magnitude: a capped quotient reads as 2^32 so it saturates below
   always_comb begin
      if (dctl.op == cau_pkg::OP_DIV) begin
         mag_re = dre.ovf ? 64'h1_0000_0000 : 64'(dre.q);
         mag_im = dim.ovf ? 64'h1_0000_0000 : 64'(dim.q);
      end else begin
         mag_re = dre.r[63:0];
         mag_im = dim.r[63:0];
      end
   end

   // clamp sign and magnitude to the 32-bit two's complement range
   always_comb begin
      sat_re = 1'b0;
      sat_im = 1'b0;
      if (!dre.neg) begin
         sat_re = (mag_re > 64'h7FFF_FFFF);
         res_re = sat_re ? 32'h7FFF_FFFF : mag_re[31:0];
      end else begin
         sat_re = (mag_re > 64'h8000_0000);
         res_re = sat_re ? 32'h8000_0000 : 32'(-mag_re[31:0]);
      end
      if (!dim.neg) begin
         sat_im = (mag_im > 64'h7FFF_FFFF);
         res_im = sat_im ? 32'h7FFF_FFFF : mag_im[31:0];
      end else begin
         sat_im = (mag_im > 64'h8000_0000);
         res_im = sat_im ? 32'h8000_0000 : 32'(-mag_im[31:0]);
      end
   end

   // division by zero wins over everything and returns zero
   always_comb begin
      if (dctl.op == cau_pkg::OP_DIV && dctl.dz) begin
         rsp_in.r_re = '0;
         rsp_in.r_im = '0;
         rsp_in.status = cau_pkg::ST_DIV_ZERO;
      end else begin
         rsp_in.r_re = res_re;
         rsp_in.r_im = res_im;
         rsp_in.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

FILE: sim/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;

   localparam int FB = 16;
   localparam int LATENCY = 38;
   localparam int N_RANDOM = 700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] ONE = 32'sh00010000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   cau_pkg::req_type req_item;
   logic             rsp_valid;
   cau_pkg::rsp_type rsp_item;

   complex_arithmetic_unit #(.FRAC_BITS(FB)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Results waiting for the strobe, oldest first.
   cau_pkg::rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      n_accepted = 0;
   int      n_results = 0;
   int      idle_cycles = 0;
   int      status_seen[4] = '{0, 0, 0, 0};

   // Clamp a wide signed value to 32 bits; raise ovf on clamp.
   function automatic logic signed [31:0] clamp_part(input logic signed [127:0] v,
                                                     inout logic ovf);
      if (v > 128'sh7FFFFFFF) begin
         ovf = 1'b1;
         return MAXV;
      end
      if (v < -128'sh80000000) begin
         ovf = 1'b1;
         return MINV;
      end
      return v[31:0];
   endfunction

   // Truncate a signed numerator scaled by 2^FB over a positive denominator, toward zero.
   function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                           input logic signed [127:0] den);
      logic signed [127:0] mag;
      logic signed [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FB) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic cau_pkg::rsp_type complex_result(input cau_pkg::req_type r);
      logic signed [127:0] ar, ai, br, bi, pr, pi, den;
      logic                ovf;
      cau_pkg::rsp_type    o;
      ar = r.a_re;
      ai = r.a_im;
      br = r.b_re;
      bi = r.b_im;
      ovf = 1'b0;
      case (cau_pkg::op_type'(r.opcode))
         cau_pkg::OP_ADD: begin
            pr = ar + br;
            pi = ai + bi;
         end
         cau_pkg::OP_SUB: begin
            pr = ar - br;
            pi = ai - bi;
         end
         cau_pkg::OP_MUL: begin
            // truncate the magnitude, keep the sign
            pr = ar * br - ai * bi;
            pi = ai * br + ar * bi;
            pr = (pr < 0) ? -((-pr) >>> FB) : (pr >>> FB);
            pi = (pi < 0) ? -((-pi) >>> FB) : (pi >>> FB);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               o.r_re = '0;
               o.r_im = '0;
               o.status = cau_pkg::ST_DIV_ZERO;
               return o;
            end
            pr = scaled_quotient(ar * br + ai * bi, den);
            pi = scaled_quotient(ai * br - ar * bi, den);
         end
      endcase
      o.r_re = clamp_part(pr, ovf);
      o.r_im = clamp_part(pi, ovf);
      o.status = ovf ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      return o;
   endfunction

   // Directed table; has_exp marks rows whose answer is typed in.
   typedef struct {
      cau_pkg::req_type r;
      logic             has_exp;
      cau_pkg::rsp_type e;
   } directed_row;

   directed_row directed_rows[$];

   function automatic cau_pkg::req_type mk(cau_pkg::op_type op, logic signed [31:0] a,
                                           logic signed [31:0] b, logic signed [31:0] c,
                                           logic signed [31:0] d);
      cau_pkg::req_type r;
      r.opcode = op;
      r.a_re = a;
      r.a_im = b;
      r.b_re = c;
      r.b_im = d;
      return r;
   endfunction

   task automatic add_row(cau_pkg::req_type r, logic has_exp, logic signed [31:0] er,
                          logic signed [31:0] ei, logic [1:0] es);
      directed_row d;
      d.r = r;
      d.has_exp = has_exp;
      d.e.r_re = er;
      d.e.r_im = ei;
      d.e.status = es;
      directed_rows.push_back(d);
   endtask

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
         2: return ($urandom_range(0, 1)) ? MAXV : MINV;
         3: return $signed(32'($urandom_range(0, 8))) - 4;
         4: return $signed(32'($urandom_range(0, 32'h7FFFFF))) - 32'sh400000;
         default: return $signed(32'($urandom_range(0, 6))) * ONE - 3 * ONE;
      endcase
   endfunction

   // Drive one item and hold until accepted; the gap before it is drawn per item.
   // start stays high afterwards so a zero gap gives back-to-back items.
   task automatic send_item(cau_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Track accepted items at the edge; push the prediction for each.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_rsp.push_back(complex_result(req_item));
         n_accepted++;
      end
   end

   // Compare each strobed result against the oldest prediction.
   always @(posedge clock) begin
      cau_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         n_results++;
         status_seen[rsp_item.status]++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_item);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.r_re !== want.r_re || rsp_item.r_im !== want.r_im ||
                rsp_item.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                           want.r_re, want.r_im, want.status,
                           rsp_item.r_re, rsp_item.r_im, rsp_item.status);
            end
         end
      end
   end

   // Watchdog: count cycles with nothing accepted on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("complex_arithmetic_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      cau_pkg::req_type r;
      int      k;
      int      drained;
      start = 1'b0;
      req_item = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Typed-in rows: simple sums, unit multiply and divide, divide by zero, saturation at both rails.
      add_row(mk(cau_pkg::OP_ADD, ONE, 2 * ONE, ONE, -ONE), 1, 2 * ONE, ONE,
              cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_ADD, MAXV, MINV, 1, -1), 1, MAXV, MINV, cau_pkg::ST_SAT);
      add_row(mk(cau_pkg::OP_SUB, MINV, MAXV, 1, -1), 1, MINV, MAXV, cau_pkg::ST_SAT);
      add_row(mk(cau_pkg::OP_SUB, 0, 0, MINV, 0), 1, MAXV, 0, cau_pkg::ST_SAT);
      add_row(mk(cau_pkg::OP_DIV, ONE, MAXV, 0, 0), 1, 0, 0, cau_pkg::ST_DIV_ZERO);
      add_row(mk(cau_pkg::OP_DIV, MINV, MINV, 0, 0), 1, 0, 0, cau_pkg::ST_DIV_ZERO);
      add_row(mk(cau_pkg::OP_MUL, ONE, 0, ONE, 0), 1, ONE, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, ONE, 0, ONE, 0), 1, ONE, 0, cau_pkg::ST_OK);
      // Predicted rows: extremes through multiply and divide, truncation signs, an add of opposite extremes.
      add_row(mk(cau_pkg::OP_MUL, MAXV, MAXV, MAXV, MAXV), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_MUL, MINV, MINV, MINV, MINV), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_MUL, MINV, MAXV, MAXV, MINV), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_MUL, -1, 1, 1, 1), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_MUL, -3, 5, 7, -9), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, MAXV, MINV, 1, 0), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, MINV, MINV, MINV, MINV), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, MAXV, MAXV, MAXV, MAXV), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, -ONE, ONE, 3 * ONE, 0), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, ONE, -ONE, 0, -7), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_DIV, 5, -5, 1, 1), 0, 0, 0, cau_pkg::ST_OK);
      add_row(mk(cau_pkg::OP_ADD, MAXV, MAXV, MINV, MINV), 0, 0, 0, cau_pkg::ST_OK);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].has_exp &&
             complex_result(directed_rows[i].r) != directed_rows[i].e) begin
            mismatches++;
            if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
         end
         send_item(directed_rows[i].r);
      end

      for (k = 0; k < N_RANDOM; k++) begin
         r.opcode = 2'($urandom_range(0, 3));
         r.a_re = rand_operand();
         r.a_im = rand_operand();
         r.b_re = rand_operand();
         r.b_im = rand_operand();
         if (r.opcode == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
            r.b_re = 0;
            r.b_im = 0;
         end
         // Hold off once mid-run until the pipe is empty.
         if (k == N_RANDOM / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         // Stretch of back-to-back items with no gaps.
         if (k >= 100 && k < 160) begin
            start <= 1'b1;
            req_item <= r;
            @(posedge clock);
            while (busy) @(posedge clock);
         end else begin
            send_item(r);
         end
      end
      start <= 1'b0;

      drained = 0;
      while (pending_rsp.size() != 0 && drained < 20 * LATENCY) begin
         @(posedge clock);
         drained++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("covered %0d items, %0d results: ok %0d, div-by-zero %0d, saturated %0d",
               n_accepted, n_results, status_seen[0], status_seen[1], status_seen[2]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("complex_arithmetic_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_rsp.size());
         $display("complex_arithmetic_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
